// ===== hw/rtl/mecanum_wheel_torque_command_defines.svh =====
// Assertion macros shared by the mecanum torque command RTL
`ifndef MECANUM_WHEEL_TORQUE_COMMAND_DEFINES_SVH
`define MECANUM_WHEEL_TORQUE_COMMAND_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define MWT_CHK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define MWT_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/mwt_pkg.sv =====
// Package: constants, types and fixed-point helpers for the mecanum torque command
package mwt_pkg;

  localparam int FRAC_BITS = 16;
  localparam int NUM_WHEELS = 4;
  localparam int DATA_W = 32;
  localparam int REG_W = 31;
  localparam int PROD_W = 2 * DATA_W - FRAC_BITS;   // product after the fraction shift
  localparam int NUM_STAGES = 9;

  // 0.00175 rounded to nearest at FRAC_BITS
  localparam logic [REG_W-1:0] TORQUE_SCALE =
    REG_W'(((64'd175 << FRAC_BITS) + 64'd50000) / 64'd100000);

  // Wheels whose vy and wz terms are subtracted
  localparam logic [NUM_WHEELS-1:0] VY_NEG = 4'b1001;
  localparam logic [NUM_WHEELS-1:0] WZ_NEG = 4'b0101;

  typedef enum logic [2:0] {
    REG_WHEEL_SCALE = 3'd0,
    REG_YAW_SCALE   = 3'd1,
    REG_STEP_TIME   = 3'd2,
    REG_KP_GAIN     = 3'd3,
    REG_KV_GAIN     = 3'd4
  } reg_idx_t;

  typedef logic signed [DATA_W-1:0] fx_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic [REG_W-1:0] ureg_t;

  // Full product, arithmetic shift right (floor)
  function automatic prod_t fx_mul(input fx_t a, input ureg_t b);
    logic signed [2*DATA_W-1:0] p;
    p = (2*DATA_W)'(a) * (2*DATA_W)'($signed({1'b0, b}));
    return p[2*DATA_W-1:FRAC_BITS];
  endfunction

  function automatic fx_t sat32(input logic signed [63:0] x);
    if (x > 64'sh0000_0000_7fff_ffff) begin
      return 32'sh7fff_ffff;
    end else if (x < -64'sh0000_0000_8000_0000) begin
      return 32'sh8000_0000;
    end else begin
      return x[DATA_W-1:0];
    end
  endfunction

endpackage

// ===== hw/rtl/mecanum_wheel_torque_command.sv =====
// Top level: mecanum wheel rate and PD torque command pipeline
//
//   channel | signals                              | direction
//   --------+--------------------------------------+----------
//   input   | in_valid, in_stall, base_*, angle_*, rate_* | in
//   output  | out_valid, out_stall, cmd_rate_*, torque_*  | out
//   config  | cfg_write, cfg_index, cfg_data        | in
//
// Nine register stages, one command per cycle while out_stall is low; the result
// is held in stage 9, which drives the outputs. One multiply or one saturating add
// sets the depth of each stage.
// Each stage holds while its successor is full and held, so bubbles close up
// under out_stall and in_stall rises only once every stage is full.
// rst clears valid bits and loads register defaults; data registers are not reset.
`include "mecanum_wheel_torque_command_defines.svh"

module mecanum_wheel_torque_command (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  mwt_pkg::fx_t          base_vx,
  input  mwt_pkg::fx_t          base_vy,
  input  mwt_pkg::fx_t          base_wz,
  input  mwt_pkg::fx_t          angle_0,
  input  mwt_pkg::fx_t          angle_1,
  input  mwt_pkg::fx_t          angle_2,
  input  mwt_pkg::fx_t          angle_3,
  input  mwt_pkg::fx_t          rate_0,
  input  mwt_pkg::fx_t          rate_1,
  input  mwt_pkg::fx_t          rate_2,
  input  mwt_pkg::fx_t          rate_3,
  output logic                  out_valid,
  input  logic                  out_stall,
  output mwt_pkg::fx_t          cmd_rate_0,
  output mwt_pkg::fx_t          cmd_rate_1,
  output mwt_pkg::fx_t          cmd_rate_2,
  output mwt_pkg::fx_t          cmd_rate_3,
  output mwt_pkg::fx_t          torque_0,
  output mwt_pkg::fx_t          torque_1,
  output mwt_pkg::fx_t          torque_2,
  output mwt_pkg::fx_t          torque_3,
  input  logic                  cfg_write,
  input  logic [2:0]            cfg_index,
  input  mwt_pkg::ureg_t        cfg_data
);
  import mwt_pkg::*;

  ureg_t wheel_scale, yaw_scale, step_time, kp_gain, kv_gain;

  logic [NUM_STAGES:1] v;
  logic [NUM_STAGES:1] adv;

  fx_t   q_in  [NUM_WHEELS];
  fx_t   dq_in [NUM_WHEELS];

  // stage registers
  prod_t s1_a, s1_b, s1_c;
  fx_t   s1_q [NUM_WHEELS];
  fx_t   s1_dq[NUM_WHEELS];
  fx_t   s2_rate[NUM_WHEELS];
  fx_t   s2_q [NUM_WHEELS];
  fx_t   s2_dq[NUM_WHEELS];
  prod_t s3_tm[NUM_WHEELS];
  prod_t s3_dv[NUM_WHEELS];
  fx_t   s3_q [NUM_WHEELS];
  fx_t   s3_rate[NUM_WHEELS];
  fx_t   s4_tgt[NUM_WHEELS];
  prod_t s4_dv[NUM_WHEELS];
  fx_t   s4_q [NUM_WHEELS];
  fx_t   s4_rate[NUM_WHEELS];
  fx_t   s5_err[NUM_WHEELS];
  prod_t s5_dv[NUM_WHEELS];
  fx_t   s5_rate[NUM_WHEELS];
  prod_t s6_ek[NUM_WHEELS];
  prod_t s6_dv[NUM_WHEELS];
  fx_t   s6_rate[NUM_WHEELS];
  fx_t   s7_raw[NUM_WHEELS];
  fx_t   s7_rate[NUM_WHEELS];
  prod_t s8_tp[NUM_WHEELS];
  fx_t   s8_rate[NUM_WHEELS];
  fx_t   s9_tq[NUM_WHEELS];
  fx_t   s9_rate[NUM_WHEELS];

  assign q_in[0]  = angle_0;
  assign q_in[1]  = angle_1;
  assign q_in[2]  = angle_2;
  assign q_in[3]  = angle_3;
  assign dq_in[0] = rate_0;
  assign dq_in[1] = rate_1;
  assign dq_in[2] = rate_2;
  assign dq_in[3] = rate_3;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_scale <= REG_W'(65536);
      yaw_scale   <= REG_W'(65536);
      step_time   <= REG_W'(66);
      kp_gain     <= REG_W'(65536);
      kv_gain     <= REG_W'(65536);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_WHEEL_SCALE: wheel_scale <= cfg_data;
        REG_YAW_SCALE:   yaw_scale   <= cfg_data;
        REG_STEP_TIME:   step_time   <= cfg_data;
        REG_KP_GAIN:     kp_gain     <= cfg_data;
        REG_KV_GAIN:     kv_gain     <= cfg_data;
        default: ;
      endcase
    end
  end

  // a stage loads when it is empty or its contents move on
  always_comb begin
    adv[NUM_STAGES] = !v[NUM_STAGES] || !out_stall;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      adv[k] = !v[k] || adv[k+1];
    end
  end

  assign in_stall = !adv[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[1]) begin
        v[1] <= in_valid;
      end
      for (int k = 2; k <= NUM_STAGES; k++) begin
        if (adv[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_a <= fx_mul(base_vx, wheel_scale);
      s1_b <= fx_mul(base_vy, wheel_scale);
      s1_c <= fx_mul(base_wz, yaw_scale);
      for (int w = 0; w < NUM_WHEELS; w++) begin
        s1_q[w]  <= q_in[w];
        s1_dq[w] <= dq_in[w];
      end
    end
    for (int w = 0; w < NUM_WHEELS; w++) begin
      if (adv[2]) begin
        s2_rate[w] <= sat32(64'(s1_a)
                            + (VY_NEG[w] ? -64'(s1_b) : 64'(s1_b))
                            + (WZ_NEG[w] ? -64'(s1_c) : 64'(s1_c)));
        s2_q[w]    <= s1_q[w];
        s2_dq[w]   <= s1_dq[w];
      end
      if (adv[3]) begin
        s3_tm[w]   <= fx_mul(s2_rate[w], step_time);
        s3_dv[w]   <= fx_mul(s2_dq[w], kv_gain);
        s3_q[w]    <= s2_q[w];
        s3_rate[w] <= s2_rate[w];
      end
      if (adv[4]) begin
        s4_tgt[w]  <= sat32(64'(s3_q[w]) + 64'(s3_tm[w]));
        s4_dv[w]   <= s3_dv[w];
        s4_q[w]    <= s3_q[w];
        s4_rate[w] <= s3_rate[w];
      end
      if (adv[5]) begin
        s5_err[w]  <= sat32(64'(s4_q[w]) - 64'(s4_tgt[w]));
        s5_dv[w]   <= s4_dv[w];
        s5_rate[w] <= s4_rate[w];
      end
      if (adv[6]) begin
        s6_ek[w]   <= fx_mul(s5_err[w], kp_gain);
        s6_dv[w]   <= s5_dv[w];
        s6_rate[w] <= s5_rate[w];
      end
      if (adv[7]) begin
        s7_raw[w]  <= sat32(-64'(s6_ek[w]) - 64'(s6_dv[w]));
        s7_rate[w] <= s6_rate[w];
      end
      if (adv[8]) begin
        s8_tp[w]   <= fx_mul(s7_raw[w], TORQUE_SCALE);
        s8_rate[w] <= s7_rate[w];
      end
      if (adv[9]) begin
        s9_tq[w]   <= sat32(64'(s8_tp[w]));
        s9_rate[w] <= s8_rate[w];
      end
    end
  end

  assign out_valid  = v[NUM_STAGES];
  assign cmd_rate_0 = s9_rate[0];
  assign cmd_rate_1 = s9_rate[1];
  assign cmd_rate_2 = s9_rate[2];
  assign cmd_rate_3 = s9_rate[3];
  assign torque_0   = s9_tq[0];
  assign torque_1   = s9_tq[1];
  assign torque_2   = s9_tq[2];
  assign torque_3   = s9_tq[3];

  `MWT_CHK_NEXT(a_in_lands, in_valid && !in_stall, v[1], "accepted transfer not in stage 1")
  `MWT_CHK_NOW(a_stall_full, in_stall, &v, "input held while pipeline has a bubble")
  `MWT_CHK_NEXT(a_hold_out, out_valid && out_stall, out_valid && $stable(s9_tq[0]) &&
    $stable(s9_rate[0]), "held result lost or changed")
  `MWT_CHK_NEXT(a_sat_hi, v[8] && adv[9] && (s8_tp[0] > prod_t'(64'sh7fff_ffff)),
    torque_0 == 32'sh7fff_ffff, "torque not clamped high")

endmodule

// ===== tb/tb_mecanum_wheel_torque_command.sv =====
// Self-checking testbench for the mecanum wheel rate and torque command pipeline
`timescale 1ns / 100ps

module tb_mecanum_wheel_torque_command;
  import mwt_pkg::*;

  localparam fx_t FX_MAX = 32'sh7fff_ffff;
  localparam fx_t FX_MIN = 32'sh8000_0000;
  localparam fx_t FX_ONE = 32'sh0001_0000;
  localparam ureg_t GAIN_MAX = 31'h7fff_ffff;
  localparam logic [2:0] FIRST_SPARE_INDEX = 3'd5;
  localparam logic [2:0] LAST_SPARE_INDEX = 3'd7;
  // wheels whose lateral and yaw terms are subtracted
  localparam logic [3:0] VY_SUB = 4'b1001;
  localparam logic [3:0] WZ_SUB = 4'b0101;
  // 0.00175 rounded to nearest
  localparam longint TORQUE_Q = ((64'd175 << FRAC_BITS) + 64'd50000) / 64'd100000;
  localparam int NUM_SETTINGS = 7;
  localparam int RANDOM_PER_SETTING = 130;
  localparam int IDLE_LIMIT = 4000;

  typedef struct packed {
    fx_t vx;
    fx_t vy;
    fx_t wz;
    logic [3:0][31:0] angle;
    logic [3:0][31:0] rate;
  } base_cmd_t;

  typedef struct packed {
    logic [3:0][31:0] cmd_rate;
    logic [3:0][31:0] torque;
  } wheel_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  logic cfg_write = 1'b0;
  logic [2:0] cfg_index = '0;
  ureg_t cfg_data = '0;
  base_cmd_t cur_cmd = '0;
  fx_t cmd_rate_0, cmd_rate_1, cmd_rate_2, cmd_rate_3;
  fx_t torque_0, torque_1, torque_2, torque_3;

  // shadow of the gain registers
  longint wheel_scale_q = 65536;
  longint yaw_scale_q = 65536;
  longint step_time_q = 66;
  longint kp_q = 65536;
  longint kv_q = 65536;

  base_cmd_t cmd_backlog[$];
  wheel_out_t wheel_cmds_due[$];

  logic in_taken = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_left = 0;
  int stall_mode = 0;
  int idle_cycles = 0;
  int cmds_sent = 0;
  int results_checked = 0;
  int field_errors = 0;

  always #5 clk = ~clk;

  mecanum_wheel_torque_command dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .base_vx   (cur_cmd.vx),
    .base_vy   (cur_cmd.vy),
    .base_wz   (cur_cmd.wz),
    .angle_0   (cur_cmd.angle[0]),
    .angle_1   (cur_cmd.angle[1]),
    .angle_2   (cur_cmd.angle[2]),
    .angle_3   (cur_cmd.angle[3]),
    .rate_0    (cur_cmd.rate[0]),
    .rate_1    (cur_cmd.rate[1]),
    .rate_2    (cur_cmd.rate[2]),
    .rate_3    (cur_cmd.rate[3]),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd_rate_0(cmd_rate_0),
    .cmd_rate_1(cmd_rate_1),
    .cmd_rate_2(cmd_rate_2),
    .cmd_rate_3(cmd_rate_3),
    .torque_0  (torque_0),
    .torque_1  (torque_1),
    .torque_2  (torque_2),
    .torque_3  (torque_3),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic longint clamp32(input longint x);
    if (x > 64'sd2147483647) begin
      return 64'sd2147483647;
    end else if (x < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return x;
  endfunction

  // full product, floor shift of the fraction bits
  function automatic longint q_scale(input longint a, input longint b);
    longint p;
    p = a * b;
    return p >>> FRAC_BITS;
  endfunction

  function automatic wheel_out_t predict_wheel_cmds(input base_cmd_t c);
    wheel_out_t r;
    longint fwd, lat, yaw, q, dq, spd, tgt, err, raw;
    fwd = q_scale(longint'(c.vx), wheel_scale_q);
    lat = q_scale(longint'(c.vy), wheel_scale_q);
    yaw = q_scale(longint'(c.wz), yaw_scale_q);
    for (int i = 0; i < 4; i++) begin
      q = $signed(c.angle[i]);
      dq = $signed(c.rate[i]);
      spd = clamp32(fwd + (VY_SUB[i] ? -lat : lat) + (WZ_SUB[i] ? -yaw : yaw));
      tgt = clamp32(q + q_scale(spd, step_time_q));
      err = clamp32(q - tgt);
      raw = clamp32(-q_scale(err, kp_q) - q_scale(dq, kv_q));
      r.cmd_rate[i] = spd[31:0];
      r.torque[i] = 32'(clamp32(q_scale(raw, TORQUE_Q)));
    end
    return r;
  endfunction

  function automatic fx_t rand_fx();
    case ($urandom_range(0, 9))
      0: return FX_MIN;
      1: return FX_MAX;
      2: return '0;
      3, 4, 5: return fx_t'($urandom_range(0, 32'h0020_0000)) - fx_t'(32'h0010_0000);
      default: return fx_t'($urandom);
    endcase
  endfunction

  function automatic ureg_t rand_gain();
    case ($urandom_range(0, 3))
      0: return ureg_t'($urandom);
      1: return ureg_t'($urandom_range(0, 32'h0010_0000));
      2: return ureg_t'($urandom_range(0, 255));
      default: return GAIN_MAX;
    endcase
  endfunction

  function automatic base_cmd_t rand_cmd();
    base_cmd_t c;
    c.vx = rand_fx();
    c.vy = rand_fx();
    c.wz = rand_fx();
    for (int i = 0; i < 4; i++) begin
      c.angle[i] = rand_fx();
      c.rate[i] = rand_fx();
    end
    return c;
  endfunction

  function automatic base_cmd_t make_cmd(input fx_t vx, input fx_t vy, input fx_t wz,
                                         input fx_t q, input fx_t dq);
    base_cmd_t c;
    c.vx = vx;
    c.vy = vy;
    c.wz = wz;
    for (int i = 0; i < 4; i++) begin
      c.angle[i] = q;
      c.rate[i] = dq;
    end
    return c;
  endfunction

  task automatic queue_corner_cmds();
    base_cmd_t c;
    cmd_backlog.push_back(make_cmd(0, 0, 0, 0, 0));
    cmd_backlog.push_back(make_cmd(FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX));
    cmd_backlog.push_back(make_cmd(FX_MIN, FX_MIN, FX_MIN, FX_MIN, FX_MIN));
    cmd_backlog.push_back(make_cmd(FX_MAX, 0, 0, 0, 0));
    cmd_backlog.push_back(make_cmd(0, FX_MIN, 0, 0, 0));
    cmd_backlog.push_back(make_cmd(0, 0, FX_MAX, 0, 0));
    cmd_backlog.push_back(make_cmd(0, 0, FX_MIN, 0, 0));
    cmd_backlog.push_back(make_cmd(FX_ONE, FX_ONE, FX_ONE, 0, 0));
    cmd_backlog.push_back(make_cmd(FX_MAX, FX_MAX, FX_MAX, FX_MIN, FX_MIN));
    cmd_backlog.push_back(make_cmd(FX_MIN, FX_MAX, FX_MIN, FX_MAX, FX_MAX));
    cmd_backlog.push_back(make_cmd(32'shaaaa_aaaa, 32'shaaaa_aaaa, 32'shaaaa_aaaa,
                                   32'shaaaa_aaaa, 32'shaaaa_aaaa));
    cmd_backlog.push_back(make_cmd(32'sh5555_5555, 32'sh5555_5555, 32'sh5555_5555,
                                   32'sh5555_5555, 32'sh5555_5555));
    cmd_backlog.push_back(make_cmd(FX_MAX, 0, 0, FX_MAX, 0));
    cmd_backlog.push_back(make_cmd(FX_MIN, 0, 0, FX_MIN, 0));
    // tiny negatives: floor rounding of every product
    cmd_backlog.push_back(make_cmd(-1, -1, -1, -1, -1));
    c = make_cmd(32'sh0002_8000, -32'sh0001_4000, 32'sh0000_c000, 0, 0);
    c.angle = {32'hffff_ffff, 32'h0, FX_MIN, FX_MAX};
    c.rate = {32'h1, 32'hffff_ffff, FX_MAX, FX_MIN};
    cmd_backlog.push_back(c);
  endtask

  task automatic write_reg(input logic [2:0] idx, input ureg_t val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_WHEEL_SCALE: wheel_scale_q = val;
      REG_YAW_SCALE:   yaw_scale_q = val;
      REG_STEP_TIME:   step_time_q = val;
      REG_KP_GAIN:     kp_q = val;
      REG_KV_GAIN:     kv_q = val;
      default: ;  // spare index: write is dropped
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_gains(input ureg_t ws, input ureg_t ys, input ureg_t st,
                           input ureg_t kp, input ureg_t kv);
    write_reg(REG_WHEEL_SCALE, ws);
    write_reg(REG_YAW_SCALE, ys);
    write_reg(REG_STEP_TIME, st);
    write_reg(REG_KP_GAIN, kp);
    write_reg(REG_KV_GAIN, kv);
  endtask

  // wait until the backlog is sent and the pipeline has fully drained
  task automatic wait_idle();
    while (cmd_backlog.size() != 0 || in_valid || wheel_cmds_due.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // sender: bursts of random length separated by random gaps
  always @(negedge clk) begin : feed_cmds
    base_cmd_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (cmd_backlog.size() != 0) begin
        nxt = cmd_backlog.pop_front();
        cur_cmd <= nxt;
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern switches to a random mode whenever its mode counter runs out
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(16, 96);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 1) == 1);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= stall_left[2];
    endcase
  end

  // input transfers: record the expected wheel commands
  always @(posedge clk) begin
    in_taken <= !rst && in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) begin
      wheel_cmds_due.push_back(predict_wheel_cmds(cur_cmd));
      cmds_sent <= cmds_sent + 1;
    end
  end

  // output transfers: compare against the oldest expectation
  always @(posedge clk) begin : check_results
    wheel_out_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got.cmd_rate = {cmd_rate_3, cmd_rate_2, cmd_rate_1, cmd_rate_0};
      got.torque = {torque_3, torque_2, torque_1, torque_0};
      if (wheel_cmds_due.size() == 0) begin
        $error("result transfer with no command outstanding");
        field_errors = field_errors + 1;
      end else begin
        want = wheel_cmds_due.pop_front();
        for (int i = 0; i < 4; i++) begin
          if (got.cmd_rate[i] !== want.cmd_rate[i]) begin
            $error("cmd_rate_%0d: expected %0d, got %0d", i,
                   $signed(want.cmd_rate[i]), $signed(got.cmd_rate[i]));
            field_errors = field_errors + 1;
          end
          if (got.torque[i] !== want.torque[i]) begin
            $error("torque_%0d: expected %0d, got %0d", i,
                   $signed(want.torque[i]), $signed(got.torque[i]));
            field_errors = field_errors + 1;
          end
        end
        results_checked <= results_checked + 1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int setting = 0; setting < NUM_SETTINGS; setting++) begin
      wait_idle();
      case (setting)
        0: ;  // reset values
        1: set_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX);
        2: set_gains('0, '0, '0, '0, '0);
        3: begin
          // plausible robot: r = 5 cm, lever 0.45 m, 1 ms period
          set_gains(31'd20 << 16, 31'd9 << 16, 31'd66, 31'd100 << 16, 31'd5 << 16);
          for (int idx = FIRST_SPARE_INDEX; idx <= LAST_SPARE_INDEX; idx++) begin
            write_reg(idx[2:0], GAIN_MAX);
          end
        end
        default: set_gains(rand_gain(), rand_gain(), rand_gain(), rand_gain(), rand_gain());
      endcase
      if (setting < 2) begin
        queue_corner_cmds();
      end
      repeat (RANDOM_PER_SETTING) cmd_backlog.push_back(rand_cmd());
    end
    wait_idle();
    repeat (NUM_STAGES + 4) @(posedge clk);
    $display("Covered %0d base commands under %0d gain settings (reset, max, zero, ",
             cmds_sent, NUM_SETTINGS);
    $display("  plausible, random); %0d results checked, %0d field mismatches",
             results_checked, field_errors);
    if (field_errors == 0 && wheel_cmds_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
